// ===== design/hsvc_pkg.sv =====
// shared types, constants and helper functions for the hsv two-class pixel classifier
package hsvc_pkg;

  localparam int unsigned DEF_FRAME_WIDTH  = 640;
  localparam int unsigned DEF_FRAME_HEIGHT = 480;
  localparam int unsigned DEF_QUEUE_DEPTH  = 2;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned ROW_W      = 9;
  localparam int unsigned PT_W       = 10;
  localparam int unsigned SUM_W      = 28;
  localparam int unsigned CNT_W      = 19;
  localparam int unsigned BOX_W      = 48;
  localparam int unsigned WL_W       = 10;
  localparam int unsigned WT_W       = 9;
  localparam int unsigned WR_W       = 11;
  localparam int unsigned WB_W       = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 232;

  localparam logic [BOX_W-1:0] FIRST_BOX_RST  = 48'd280721581020160;
  localparam logic [BOX_W-1:0] SECOND_BOX_RST = 48'd280809246563860;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_BOX  = 3'd0,
    REG_SECOND_BOX = 3'd1,
    REG_WIN_LEFT   = 3'd2,
    REG_WIN_TOP    = 3'd3,
    REG_WIN_RIGHT  = 3'd4,
    REG_WIN_BOTTOM = 3'd5,
    REG_WIN_EN     = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_FIRST  = 2'd1,
    CLS_SECOND = 2'd2
  } cls_e;

  typedef struct packed {
    cls_e             cls;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             in_win;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [PT_W-1:0] col;
    logic [PT_W-1:0] row;
  } point_t;

  // first member lands in the highest bits
  typedef struct packed {
    point_t           topmost;
    point_t           leftmost;
    point_t           lowest;
    point_t           rightmost;
    logic [CNT_W-1:0] second_cnt;
    logic [SUM_W-1:0] second_row;
    logic [SUM_W-1:0] second_col;
    logic [CNT_W-1:0] first_cnt;
    logic [SUM_W-1:0] first_row;
    logic [SUM_W-1:0] first_col;
    cls_e             cls;
  } result_t;

  function automatic logic in_box(input logic [BOX_W-1:0] box,
                                  input logic [CH_W-1:0] hue,
                                  input logic [CH_W-1:0] sat,
                                  input logic [CH_W-1:0] val);
    return (hue >= box[7:0])   && (hue <= box[15:8]) &&
           (sat >= box[23:16]) && (sat <= box[31:24]) &&
           (val >= box[39:32]) && (val <= box[47:40]);
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
                                               input logic [PT_W-1:0] add);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(add);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] acc);
    return (&acc) ? acc : acc + CNT_W'(1);
  endfunction

endpackage

// ===== design/hsvc_front.sv =====
// front part: configuration registers, box and window tests, one request stage
module hsvc_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hsvc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hsvc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [hsvc_pkg::CH_W-1:0]        hue_i,
  input  logic [hsvc_pkg::CH_W-1:0]        saturation_i,
  input  logic [hsvc_pkg::CH_W-1:0]        brightness_i,
  input  logic [hsvc_pkg::COL_W-1:0]       column_i,
  input  logic [hsvc_pkg::ROW_W-1:0]       row_i,
  input  logic                             frame_last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output hsvc_pkg::item_t                  out_item_o
);
  import hsvc_pkg::*;

  logic [BOX_W-1:0] first_box_q, second_box_q;
  logic [WL_W-1:0]  win_left_q;
  logic [WT_W-1:0]  win_top_q;
  logic [WR_W-1:0]  win_right_q;
  logic [WB_W-1:0]  win_bottom_q;
  logic             win_en_q;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_box_q  <= FIRST_BOX_RST;
      second_box_q <= SECOND_BOX_RST;
      win_left_q   <= '0;
      win_top_q    <= '0;
      win_right_q  <= '0;
      win_bottom_q <= '0;
      win_en_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FIRST_BOX:  first_box_q  <= cfg_data_i[BOX_W-1:0];
        REG_SECOND_BOX: second_box_q <= cfg_data_i[BOX_W-1:0];
        REG_WIN_LEFT:   win_left_q   <= cfg_data_i[WL_W-1:0];
        REG_WIN_TOP:    win_top_q    <= cfg_data_i[WT_W-1:0];
        REG_WIN_RIGHT:  win_right_q  <= cfg_data_i[WR_W-1:0];
        REG_WIN_BOTTOM: win_bottom_q <= cfg_data_i[WB_W-1:0];
        REG_WIN_EN:     win_en_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    item_d = item_q;
    if (accept) begin
      priority if (in_box(first_box_q, hue_i, saturation_i, brightness_i)) begin
        item_d.cls = CLS_FIRST;
      end else if (in_box(second_box_q, hue_i, saturation_i, brightness_i)) begin
        item_d.cls = CLS_SECOND;
      end else begin
        item_d.cls = CLS_NONE;
      end
      item_d.col    = column_i;
      item_d.row    = row_i;
      item_d.in_win = win_en_q &&
                      (WL_W'(column_i) > win_left_q) && (WR_W'(column_i) < win_right_q) &&
                      (WT_W'(row_i) > win_top_q) && (WB_W'(row_i) < win_bottom_q);
      item_d.last   = frame_last_i;
    end
  end

  assign valid_d = accept || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// ===== design/hsvc_queue.sv =====
// short queue of classified pixels between the front and back parts
module hsvc_queue #(
  parameter int unsigned DEPTH = hsvc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  hsvc_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output hsvc_pkg::item_t pop_item_o
);
  import hsvc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);

  item_t              mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0]  count_q, count_d;
  logic               push, pop;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign push_ready_o = count_q != CNT_QW'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CNT_QW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== design/hsvc_back.sv =====
// back part: per-class accumulators, extreme points and the result register
module hsvc_back #(
  parameter int unsigned FRAME_WIDTH  = hsvc_pkg::DEF_FRAME_WIDTH,
  parameter int unsigned FRAME_HEIGHT = hsvc_pkg::DEF_FRAME_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hsvc_pkg::item_t   in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hsvc_pkg::result_t out_result_o,
  output logic              out_totals_valid_o
);
  import hsvc_pkg::*;

  localparam logic [PT_W-1:0] MIN_COL_RST = PT_W'(FRAME_WIDTH - 1);
  localparam logic [PT_W-1:0] MIN_ROW_RST = PT_W'(FRAME_HEIGHT - 1);
  localparam point_t MAX_PT_RST = '{col: '0, row: '0};
  localparam point_t MIN_COL_PT_RST = '{col: MIN_COL_RST, row: '0};
  localparam point_t MIN_ROW_PT_RST = '{col: '0, row: MIN_ROW_RST};

  logic [SUM_W-1:0] fcol_q, fcol_d, fcol_n, frow_q, frow_d, frow_n;
  logic [SUM_W-1:0] scol_q, scol_d, scol_n, srow_q, srow_d, srow_n;
  logic [CNT_W-1:0] fcnt_q, fcnt_d, fcnt_n, scnt_q, scnt_d, scnt_n;
  point_t           mxc_q, mxc_d, mxc_n, mxr_q, mxr_d, mxr_n;
  point_t           mnc_q, mnc_d, mnc_n, mnr_q, mnr_d, mnr_n;
  point_t           cur;
  logic             is_first, is_second, track, pop;
  logic             out_valid_q, out_valid_d, tot_q, tot_d;
  result_t          res_q, res_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign pop        = in_valid_i && in_ready_o;

  always_comb begin
    cur       = '{col: in_item_i.col, row: PT_W'(in_item_i.row)};
    is_first  = in_item_i.cls == CLS_FIRST;
    is_second = in_item_i.cls == CLS_SECOND;
    track     = is_second && in_item_i.in_win;

    fcol_n = is_first ? sat_sum(fcol_q, in_item_i.col) : fcol_q;
    frow_n = is_first ? sat_sum(frow_q, PT_W'(in_item_i.row)) : frow_q;
    fcnt_n = is_first ? sat_inc(fcnt_q) : fcnt_q;
    scol_n = is_second ? sat_sum(scol_q, in_item_i.col) : scol_q;
    srow_n = is_second ? sat_sum(srow_q, PT_W'(in_item_i.row)) : srow_q;
    scnt_n = is_second ? sat_inc(scnt_q) : scnt_q;
    mxc_n  = (track && (mxc_q.col < cur.col)) ? cur : mxc_q;
    mxr_n  = (track && (mxr_q.row < cur.row)) ? cur : mxr_q;
    mnc_n  = (track && (mnc_q.col > cur.col)) ? cur : mnc_q;
    mnr_n  = (track && (mnr_q.row > cur.row)) ? cur : mnr_q;

    fcol_d = fcol_q; frow_d = frow_q; fcnt_d = fcnt_q;
    scol_d = scol_q; srow_d = srow_q; scnt_d = scnt_q;
    mxc_d  = mxc_q;  mxr_d  = mxr_q;  mnc_d  = mnc_q;  mnr_d = mnr_q;
    res_d  = res_q;
    tot_d  = tot_q;

    if (pop) begin
      res_d     = '0;
      res_d.cls = in_item_i.cls;
      tot_d     = in_item_i.last;
      if (in_item_i.last) begin
        res_d.first_col  = fcol_n;
        res_d.first_row  = frow_n;
        res_d.first_cnt  = fcnt_n;
        res_d.second_col = scol_n;
        res_d.second_row = srow_n;
        res_d.second_cnt = scnt_n;
        res_d.rightmost  = mxc_n;
        res_d.lowest     = mxr_n;
        res_d.leftmost   = mnc_n;
        res_d.topmost    = mnr_n;
        fcol_d = '0; frow_d = '0; fcnt_d = '0;
        scol_d = '0; srow_d = '0; scnt_d = '0;
        mxc_d  = MAX_PT_RST;
        mxr_d  = MAX_PT_RST;
        mnc_d  = MIN_COL_PT_RST;
        mnr_d  = MIN_ROW_PT_RST;
      end else begin
        fcol_d = fcol_n; frow_d = frow_n; fcnt_d = fcnt_n;
        scol_d = scol_n; srow_d = srow_n; scnt_d = scnt_n;
        mxc_d  = mxc_n;  mxr_d  = mxr_n;  mnc_d  = mnc_n;  mnr_d = mnr_n;
      end
    end
  end

  assign out_valid_d = pop || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      fcol_q <= '0; frow_q <= '0; fcnt_q <= '0;
      scol_q <= '0; srow_q <= '0; scnt_q <= '0;
      mxc_q  <= MAX_PT_RST;
      mxr_q  <= MAX_PT_RST;
      mnc_q  <= MIN_COL_PT_RST;
      mnr_q  <= MIN_ROW_PT_RST;
    end else begin
      out_valid_q <= out_valid_d;
      fcol_q <= fcol_d; frow_q <= frow_d; fcnt_q <= fcnt_d;
      scol_q <= scol_d; srow_q <= srow_d; scnt_q <= scnt_d;
      mxc_q  <= mxc_d;  mxr_q  <= mxr_d;  mnc_q  <= mnc_d;  mnr_q <= mnr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    tot_q <= tot_d;
  end

  assign out_valid_o        = out_valid_q;
  assign out_result_o       = res_q;
  assign out_totals_valid_o = tot_q;

endmodule

// ===== design/hsv_two_class_pixel_classifier_top.sv =====
// top level of the hsv two-class pixel classifier
// Classifies one HSV pixel per request against two hue/saturation/value boxes (first box wins)
// and returns one result per pixel; the result of the pixel marked tlast carries the frame
// totals (per-class column sums, row sums and counts, and four extreme points of windowed
// second-class pixels), after which the totals restart. A pixel can be taken every clock while
// the output is not stalled, a rate set by the back part's accumulate-and-compare step. Each
// request passes the classify stage, queue and result register, waiting while output stalls.
// The user must write configuration only while the block is idle, which is not enforced.
module hsv_two_class_pixel_classifier_top #(
  parameter int unsigned FRAME_WIDTH  = hsvc_pkg::DEF_FRAME_WIDTH,
  parameter int unsigned FRAME_HEIGHT = hsvc_pkg::DEF_FRAME_HEIGHT,
  parameter int unsigned QUEUE_DEPTH  = hsvc_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hsvc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hsvc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // hue, saturation, brightness, column, row, zero fill
  input  logic [hsvc_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  input  logic                             s_axis_tlast_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // pixel_class, first_column_sum, first_row_sum, first_count, second_column_sum,
  // second_row_sum, second_count, rightmost_point, lowest_point, leftmost_point,
  // topmost_point
  output logic [hsvc_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // totals_valid
  output logic                             m_axis_tuser_o
);
  import hsvc_pkg::*;

  logic    fr_valid, q_in_ready, q_valid, bk_ready;
  item_t   fr_item, q_item;
  result_t result;

  hsvc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .hue_i        (s_axis_tdata_i[7:0]),
    .saturation_i (s_axis_tdata_i[15:8]),
    .brightness_i (s_axis_tdata_i[23:16]),
    .column_i     (s_axis_tdata_i[33:24]),
    .row_i        (s_axis_tdata_i[42:34]),
    .frame_last_i (s_axis_tlast_i),
    .out_valid_o  (fr_valid),
    .out_ready_i  (q_in_ready),
    .out_item_o   (fr_item)
  );

  hsvc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (q_in_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (bk_ready),
    .pop_item_o   (q_item)
  );

  hsvc_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (q_valid),
    .in_ready_o         (bk_ready),
    .in_item_i          (q_item),
    .out_valid_o        (m_axis_tvalid_o),
    .out_ready_i        (m_axis_tready_i),
    .out_result_o       (result),
    .out_totals_valid_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = result;

  // totals are zero on every result but the frame's last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[OUT_DATA_W-1:2] == '0)
    else $error("totals not zero on a non-final result");

  // a full queue always has an entry to hand to the back part
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_in_ready |-> q_valid)
    else $error("queue refuses requests while empty");

  // a pixel held in the classify stage is pushed as soon as the queue has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_valid && q_in_ready |=> !fr_valid || $past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("classified pixel not moved into queue");

endmodule
